### rtl/sdp_pkg.sv
// Shared types, constants and helpers for the stereo disparity to point block.
// No dependencies; imported by every module of the block.
package sdp_pkg;

    localparam int DIV_W    = 40;
    localparam int DEN_W    = 16;
    localparam int SIDE_W   = 50;
    localparam int DEPTH_W  = 24;
    localparam int COORD_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL    = 3'd0,
        CFG_CENTER_X = 3'd1,
        CFG_CENTER_Y = 3'd2,
        CFG_BASELINE = 3'd3,
        CFG_Z_MIN    = 3'd4,
        CFG_Z_MAX    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0]        column;
        logic [11:0]        row;
        logic signed [15:0] disparity;
        logic [7:0]         blue_in;
        logic [7:0]         green_in;
        logic [7:0]         red_in;
    } t_pixel_in;

    typedef struct packed {
        logic [23:0]        depth_mm;
        logic               point_valid;
        logic signed [31:0] x_mm;
        logic signed [31:0] y_mm;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
    } t_point_out;

    // magnitude quotient plus sign -> saturated signed 32-bit value
    function automatic logic signed [COORD_W-1:0] sat_apply(
        input logic [DIV_W-1:0] q,
        input logic             neg
    );
        logic signed [COORD_W-1:0] res;
        if (neg) begin
            if (q > DIV_W'(64'h8000_0000)) begin
                res = 32'sh8000_0000;
            end else begin
                res = -$signed(q[COORD_W-1:0]);
            end
        end else begin
            if (q > DIV_W'(64'h7FFF_FFFF)) begin
                res = 32'sh7FFF_FFFF;
            end else begin
                res = $signed(q[COORD_W-1:0]);
            end
        end
        return res;
    endfunction

endpackage

### rtl/sdp_divider.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on sdp_pkg for widths; carries a sideband word alongside each item.
module sdp_divider
    import sdp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DIV_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DIV_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [DIV_W];
    logic [DEN_W-1:0]  r_rem  [DIV_W];
    logic [DIV_W-1:0]  r_num  [DIV_W];
    logic [DIV_W-1:0]  r_quo  [DIV_W];
    logic [DEN_W-1:0]  r_den  [DIV_W];
    logic [SIDE_W-1:0] r_side [DIV_W];

    logic              n_v    [DIV_W];
    logic [DEN_W-1:0]  n_rem  [DIV_W];
    logic [DIV_W-1:0]  n_num  [DIV_W];
    logic [DIV_W-1:0]  n_quo  [DIV_W];
    logic [DEN_W-1:0]  n_den  [DIV_W];
    logic [SIDE_W-1:0] n_side [DIV_W];

    always_comb begin
        logic              p_v;
        logic [DEN_W-1:0]  p_rem;
        logic [DIV_W-1:0]  p_num;
        logic [DIV_W-1:0]  p_quo;
        logic [DEN_W-1:0]  p_den;
        logic [SIDE_W-1:0] p_side;
        logic [DEN_W:0]    partial;
        logic [DEN_W:0]    diff;
        logic              ge;
        for (int k = 0; k < DIV_W; k++) begin
            if (k == 0) begin
                p_v = i_valid; p_rem = '0; p_num = i_num;
                p_quo = '0; p_den = i_den; p_side = i_side;
            end else begin
                p_v = r_v[k-1]; p_rem = r_rem[k-1]; p_num = r_num[k-1];
                p_quo = r_quo[k-1]; p_den = r_den[k-1]; p_side = r_side[k-1];
            end
            partial  = {p_rem, p_num[DIV_W-1]};
            diff     = partial - {1'b0, p_den};
            ge       = (partial >= {1'b0, p_den});
            n_v[k]   = p_v;
            n_rem[k] = ge ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            n_num[k] = {p_num[DIV_W-2:0], 1'b0};
            n_quo[k] = {p_quo[DIV_W-2:0], ge};
            n_den[k] = p_den;
            n_side[k] = p_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_W; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < DIV_W; k++) r_v[k] <= n_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_num[k]  <= n_num[k];
                r_quo[k]  <= n_quo[k];
                r_den[k]  <= n_den[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid = r_v[DIV_W-1];
    assign o_quot  = r_quo[DIV_W-1];
    assign o_side  = r_side[DIV_W-1];

endmodule

### rtl/stereo_disparity_to_point.sv
// Top level: disparity to depth, reprojection to X/Y, colour pass-through.
// Depends on sdp_pkg and sdp_divider.
//
//  channel | direction | handshake           | payload
//  in      | input     | i_in_valid/o_in_stall   | t_pixel_in
//  out     | output    | o_out_valid/i_out_stall | t_point_out
//  cfg     | input     | i_cfg_valid/o_cfg_ready | index 3b, data 24b
//
// One pixel per cycle while the output is not stalled; the path runs through two 40-stage
// divider pipelines (depth, then X and Y in parallel) plus four register stages.
// Reset is synchronous, active low; clears valids and loads register defaults.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module stereo_disparity_to_point
    import sdp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_pixel_in            i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_point_out           o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [15:0] r_focal, r_cx, r_cy, r_base;
    logic [23:0] r_zmin, r_zmax;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= 16'd16;
            r_cx    <= '0;
            r_cy    <= '0;
            r_base  <= 16'd16;
            r_zmin  <= '0;
            r_zmax  <= 24'hFF_FFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FOCAL:    r_focal <= i_cfg_data[15:0];
                CFG_CENTER_X: r_cx    <= i_cfg_data[15:0];
                CFG_CENTER_Y: r_cy    <= i_cfg_data[15:0];
                CFG_BASELINE: r_base  <= i_cfg_data[15:0];
                CFG_Z_MIN:    r_zmin  <= i_cfg_data;
                CFG_Z_MAX:    r_zmax  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // stage A: f*B and disparity check
    logic              r_a_v;
    logic [31:0]       r_a_prod;
    logic [15:0]       r_a_den;
    logic [SIDE_W-1:0] r_a_side;
    logic              a_ok;

    assign a_ok = (i_in_data.disparity > 16'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (en)  r_a_v <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_prod <= 32'(r_focal) * 32'(r_base);
            r_a_den  <= i_in_data.disparity;
            r_a_side <= {1'b0, a_ok, i_in_data.column, i_in_data.row,
                         i_in_data.blue_in, i_in_data.green_in, i_in_data.red_in};
        end
    end

    logic              d1_v;
    logic [DIV_W-1:0]  d1_q;
    logic [SIDE_W-1:0] d1_side;

    sdp_divider u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_v),
        .i_num   ({8'd0, r_a_prod}),
        .i_den   (r_a_den),
        .i_side  (r_a_side),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_side  (d1_side)
    );

    // stage C: range check and offsets
    logic        c_ok;
    logic [16:0] c_ox, c_oy;
    assign c_ok = d1_side[48] && (d1_q != '0) && (d1_q >= {16'd0, r_zmin})
                  && (d1_q <= {16'd0, r_zmax});
    assign c_ox = {1'b0, d1_side[47:36], 4'd0} - {1'b0, r_cx};
    assign c_oy = {1'b0, d1_side[35:24], 4'd0} - {1'b0, r_cy};

    logic        r_c_v, r_c_ok, r_c_xn, r_c_yn;
    logic [23:0] r_c_depth, r_c_col;
    logic [15:0] r_c_ax, r_c_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else if (en)  r_c_v <= d1_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ok    <= c_ok;
            r_c_depth <= c_ok ? d1_q[23:0] : 24'd0;
            r_c_xn    <= c_ox[16];
            r_c_yn    <= c_oy[16];
            r_c_ax    <= c_ox[16] ? 16'(-c_ox) : c_ox[15:0];
            r_c_ay    <= c_oy[16] ? 16'(-c_oy) : c_oy[15:0];
            r_c_col   <= d1_side[23:0];
        end
    end

    // stage D: |offset| * Z
    logic              r_d_v;
    logic [DIV_W-1:0]  r_d_px, r_d_py;
    logic [SIDE_W-1:0] r_d_side2, r_d_side3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_v <= 1'b0;
        else if (en)  r_d_v <= r_c_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_px    <= DIV_W'(r_c_ax) * DIV_W'(r_c_depth);
            r_d_py    <= DIV_W'(r_c_ay) * DIV_W'(r_c_depth);
            r_d_side2 <= {r_c_depth, r_c_ok, r_c_xn, r_c_col};
            r_d_side3 <= {{(SIDE_W-1){1'b0}}, r_c_yn};
        end
    end

    logic              d2_v, d3_v;
    logic [DIV_W-1:0]  d2_q, d3_q;
    logic [SIDE_W-1:0] d2_side, d3_side;

    sdp_divider u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_num   (r_d_px),
        .i_den   (r_focal),
        .i_side  (r_d_side2),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_side  (d2_side)
    );

    sdp_divider u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_num   (r_d_py),
        .i_den   (r_focal),
        .i_side  (r_d_side3),
        .o_valid (d3_v),
        .o_quot  (d3_q),
        .o_side  (d3_side)
    );

    // stage E: sign, saturation, output register
    logic       r_out_v;
    t_point_out r_out;
    t_point_out n_out;

    always_comb begin
        n_out.depth_mm    = d2_side[49:26];
        n_out.point_valid = d2_side[25];
        n_out.x_mm        = d2_side[25] ? sat_apply(d2_q, d2_side[24]) : 32'sd0;
        n_out.y_mm        = d2_side[25] ? sat_apply(d3_q, d3_side[0])  : 32'sd0;
        n_out.blue_out    = d2_side[23:16];
        n_out.green_out   = d2_side[15:8];
        n_out.red_out     = d2_side[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (en)  r_out_v <= d2_v && d3_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

### rtl/sdp_checker.sv
// Port-level checker for stereo_disparity_to_point, attached by bind.
// Depends on sdp_pkg for the payload types.
module sdp_checker
    import sdp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_point_out o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.point_valid |->
        o_out_data.depth_mm == '0 && o_out_data.x_mm == '0 && o_out_data.y_mm == '0)
        else $error("invalid point with nonzero fields");

    a_valid_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.point_valid |-> o_out_data.depth_mm != '0)
        else $error("valid point with zero depth");

    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall not tied to output backpressure");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind stereo_disparity_to_point sdp_checker u_sdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
